>>> hdl/rpv_pkg.sv
// Shared types, constants and helpers for the regular polygon vertex generator.
package rpv_pkg;

    localparam int COORD_W     = 32;
    localparam int RADIUS_W    = 31;
    localparam int ANGLE_W     = 16;
    localparam int SIDE_W      = 7;
    localparam int VNUM_W      = 6;
    localparam int SIDE_FLOOR  = 3;
    localparam int SIDE_CEIL   = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // divider: 64-bit dividend, 31-bit divisor, quotient known to fit 34 bits
    localparam int DVD_W  = 64;
    localparam int DVS_W  = 31;
    localparam int QUO_W  = 34;
    localparam int DCNT_W = $clog2(QUO_W);

    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;
    localparam logic [31:0] QUARTER     = 32'h4000_0000;

    typedef enum logic [0:0] {
        CFG_NUM_SIDES = 1'b0,
        CFG_POLY_MODE = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SEL_RAD,
        SEL_COS,
        SEL_SIN
    } t_sin_sel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_HALF_DST,
        S_HALF_DWT,
        S_RAD_DST,
        S_RAD_DWT,
        S_VTX_DST,
        S_VTX_DWT,
        S_SIN_Q,
        S_SIN_X,
        S_SIN_X2,
        S_SIN_T0,
        S_SIN_PT,
        S_SIN_RCP,
        S_SIN_QT,
        S_SIN_S,
        S_SIN_END,
        S_SC_XA,
        S_SC_XB,
        S_SC_XC,
        S_SC_YA,
        S_SC_YB,
        S_SC_YC,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
        logic        [RADIUS_W-1:0] rad;
        logic        [ANGLE_W-1:0]  start;
        logic        [SIDE_W-1:0]   n;
        logic                       circ;
    } t_job;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quot;
    } t_div_rsp;

    // nested Taylor divisors, innermost first: rounded-up reciprocal of the odd
    // part, exact for a 31-bit dividend once the power of two is shifted out
    function automatic logic [31:0] sin_recip(input logic [2:0] k);
        logic [31:0] m;
        begin
            case (k)
                3'd0:    m = 32'd2498890064; // 110 = 2 * 55
                3'd1:    m = 32'd3817748708; // 72 = 8 * 9
                3'd2:    m = 32'd3272356036; // 42 = 2 * 21
                3'd3:    m = 32'd3435973837; // 20 = 4 * 5
                default: m = 32'd2863311531; // 6 = 2 * 3
            endcase
            return m;
        end
    endfunction

endpackage

>>> hdl/regular_polygon_vertex_generator_unit.sv
// Regular polygon vertex generator: one input (center, radius, start angle)
// yields num_sides vertices in order, the last one flagged. Inputs are queued
// two deep while a polygon is computed. Each vertex is worked in these steps:
// the vertex angle on the shared bit-serial divider, cosine and sine (five
// Taylor terms, each a multiply and a reciprocal multiply on one shared 32x32
// multiplier), the two scaled offsets and the emit. A polygon first takes its
// job; circumscribed mode adds a radius correction per polygon (half-step
// angle division, its cosine and one more division). The result register lets
// the next vertex be worked while one waits to be taken; the back stalls only
// when a finished vertex meets a result still waiting.
module regular_polygon_vertex_generator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [0:0]                          i_cfg_index,
    input  logic [rpv_pkg::SIDE_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [rpv_pkg::COORD_W-1:0]  i_center_x,
    input  logic signed [rpv_pkg::COORD_W-1:0]  i_center_y,
    input  logic [rpv_pkg::RADIUS_W-1:0]        i_circle_radius,
    input  logic [rpv_pkg::ANGLE_W-1:0]         i_start_angle,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [rpv_pkg::COORD_W-1:0]  o_vertex_x,
    output logic signed [rpv_pkg::COORD_W-1:0]  o_vertex_y,
    output logic [rpv_pkg::VNUM_W-1:0]          o_vertex_number,
    output logic                                o_last_vertex,
    output logic                                o_clipped
);

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    rpv_pkg::t_job     q_in_job;
    rpv_pkg::t_job     q_out_job;
    rpv_pkg::t_div_req div_req;
    rpv_pkg::t_div_rsp div_rsp;

    rpv_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_circle_radius (i_circle_radius),
        .i_start_angle   (i_start_angle),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_job         (q_in_job)
    );

    rpv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_out_job)
    );

    rpv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    rpv_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (q_valid),
        .i_job           (q_out_job),
        .o_job_pop       (q_pop),
        .o_div_req       (div_req),
        .i_div_rsp       (div_rsp),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_vertex_x      (o_vertex_x),
        .o_vertex_y      (o_vertex_y),
        .o_vertex_number (o_vertex_number),
        .o_last_vertex   (o_last_vertex),
        .o_clipped       (o_clipped)
    );

endmodule

>>> hdl/rpv_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module rpv_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rpv_pkg::t_div_req i_req,
    output rpv_pkg::t_div_rsp o_rsp
);

    logic                        r_busy;
    logic                        r_done;
    logic [rpv_pkg::DCNT_W-1:0]  r_cnt;
    logic [31:0]                 r_rem;
    logic [rpv_pkg::QUO_W-1:0]   r_quo;
    logic [rpv_pkg::DVS_W-1:0]   r_dvs;

    logic [31:0] trial;
    logic        ge;

    assign trial = {r_rem[30:0], r_quo[rpv_pkg::QUO_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rpv_pkg::DCNT_W'(rpv_pkg::QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            // upper dividend bits are already below the divisor
            r_rem <= {2'b00, i_req.dividend[rpv_pkg::DVD_W-1:rpv_pkg::QUO_W]};
            r_quo <= i_req.dividend[rpv_pkg::QUO_W-1:0];
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? (trial - {1'b0, r_dvs}) : trial;
            r_quo <= {r_quo[rpv_pkg::QUO_W-2:0], ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

>>> hdl/rpv_fifo.sv
// Two-entry job queue between the front and the back.
module rpv_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rpv_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output rpv_pkg::t_job o_job
);

    rpv_pkg::t_job              r_mem [rpv_pkg::QUEUE_DEPTH];
    logic [rpv_pkg::QPTR_W-1:0] r_wptr;
    logic [rpv_pkg::QPTR_W-1:0] r_rptr;
    logic [rpv_pkg::QCNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + 1'b1;
            if (i_pop)  r_rptr <= r_rptr + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_job;
    end

    assign o_full  = r_cnt == rpv_pkg::QCNT_W'(rpv_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rptr];

endmodule

>>> hdl/rpv_front.sv
// Front end: configuration registers, input acceptance and job building.
module rpv_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [0:0]                          i_cfg_index,
    input  logic [rpv_pkg::SIDE_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [rpv_pkg::COORD_W-1:0]  i_center_x,
    input  logic signed [rpv_pkg::COORD_W-1:0]  i_center_y,
    input  logic [rpv_pkg::RADIUS_W-1:0]        i_circle_radius,
    input  logic [rpv_pkg::ANGLE_W-1:0]         i_start_angle,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output rpv_pkg::t_job                       o_q_job
);

    logic [rpv_pkg::SIDE_W-1:0] r_num_sides;
    logic                       r_poly_mode;
    logic [rpv_pkg::SIDE_W-1:0] n_clamp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_sides <= rpv_pkg::SIDE_W'(5);
            r_poly_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (rpv_pkg::t_cfg_idx'(i_cfg_index))
                rpv_pkg::CFG_NUM_SIDES: r_num_sides <= i_cfg_data;
                rpv_pkg::CFG_POLY_MODE: r_poly_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_num_sides < rpv_pkg::SIDE_W'(rpv_pkg::SIDE_FLOOR))
            n_clamp = rpv_pkg::SIDE_W'(rpv_pkg::SIDE_FLOOR);
        else if (r_num_sides > rpv_pkg::SIDE_W'(rpv_pkg::SIDE_CEIL))
            n_clamp = rpv_pkg::SIDE_W'(rpv_pkg::SIDE_CEIL);
        else
            n_clamp = r_num_sides;
    end

    assign o_in_ready    = !i_q_full;
    assign o_q_push      = i_in_valid && !i_q_full;
    assign o_q_job.cx    = i_center_x;
    assign o_q_job.cy    = i_center_y;
    assign o_q_job.rad   = i_circle_radius;
    assign o_q_job.start = i_start_angle;
    assign o_q_job.n     = n_clamp;
    assign o_q_job.circ  = r_poly_mode;

endmodule

>>> hdl/rpv_back.sv
// Back end: sequencer with shared multiplier and divider, output register.
module rpv_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_job_valid,
    input  rpv_pkg::t_job                       i_job,
    output logic                                o_job_pop,
    output rpv_pkg::t_div_req                   o_div_req,
    input  rpv_pkg::t_div_rsp                   i_div_rsp,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [rpv_pkg::COORD_W-1:0]  o_vertex_x,
    output logic signed [rpv_pkg::COORD_W-1:0]  o_vertex_y,
    output logic [rpv_pkg::VNUM_W-1:0]          o_vertex_number,
    output logic                                o_last_vertex,
    output logic                                o_clipped
);

    rpv_pkg::t_state   r_state, n_state;
    rpv_pkg::t_job     r_job;
    rpv_pkg::t_sin_sel r_sel;
    logic [33:0]       r_rad;
    logic [6:0]        r_i;
    logic [2:0]        r_k;
    logic [31:0]       r_ph;
    logic [31:0]       r_vph;
    logic [30:0]       r_x;
    logic [31:0]       r_x2;
    logic [30:0]       r_t;
    logic [63:0]       r_prod;
    logic [30:0]       r_cos_mag;
    logic              r_cos_neg;
    logic [30:0]       r_sin_mag;
    logic              r_sin_neg;
    logic [50:0]       r_a;
    logic [31:0]       r_vx;
    logic              r_clip_x;
    logic [31:0]       r_vy;
    logic              r_vclip;

    logic              r_out_valid;
    logic [31:0]       r_out_x;
    logic [31:0]       r_out_y;
    logic [5:0]        r_out_num;
    logic              r_out_last;
    logic              r_out_clip;

    logic              out_free;
    logic              is_last;
    logic [30:0]       q_sin;
    logic [31:0]       s_full;
    logic [30:0]       s_cap;
    logic [6:0]        k_off;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic              mul_en;
    logic [63:0]       mul_p;
    logic [30:0]       rcp_dvd;
    logic [30:0]       rcp_quo;
    logic              sc_y;
    logic [30:0]       sc_mag;
    logic              sc_neg;
    logic [31:0]       sc_ctr;
    logic [51:0]       sc_sum;
    logic signed [38:0] sc_off;
    logic signed [38:0] sc_res;
    logic [31:0]       sc_sat;
    logic              sc_clip;
    logic [31:0]       vtx_ph;

    assign out_free = !r_out_valid || i_out_ready;
    assign is_last  = (r_i + 7'd1) == r_job.n;
    assign q_sin    = r_ph[30] ? (rpv_pkg::ONE_Q30 - {1'b0, r_ph[29:0]})
                               : {1'b0, r_ph[29:0]};
    assign s_full   = r_prod[61:30];
    assign s_cap    = (s_full > {1'b0, rpv_pkg::ONE_Q30}) ? rpv_pkg::ONE_Q30 : s_full[30:0];
    assign vtx_ph   = {r_job.start, 16'd0} + i_div_rsp.quot[31:0];

    // Taylor term quotient by reciprocal multiply: dividend is x2*t >> 30,
    // first stripped of the divisor's power of two, then scaled back down
    always_comb begin
        case (r_k)
            3'd0: begin
                rcp_dvd = r_prod[61:31];
                rcp_quo = {4'd0, r_prod[63:37]};
            end
            3'd1: begin
                rcp_dvd = {2'd0, r_prod[61:33]};
                rcp_quo = {2'd0, r_prod[63:35]};
            end
            3'd2: begin
                rcp_dvd = r_prod[61:31];
                rcp_quo = {3'd0, r_prod[63:36]};
            end
            3'd3: begin
                rcp_dvd = {1'b0, r_prod[61:32]};
                rcp_quo = {1'b0, r_prod[63:34]};
            end
            default: begin
                rcp_dvd = r_prod[61:31];
                rcp_quo = r_prod[63:33];
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rpv_pkg::S_IDLE:
                if (i_job_valid)
                    n_state = i_job.circ ? rpv_pkg::S_HALF_DST : rpv_pkg::S_VTX_DST;
            rpv_pkg::S_HALF_DST: n_state = rpv_pkg::S_HALF_DWT;
            rpv_pkg::S_HALF_DWT: if (i_div_rsp.done) n_state = rpv_pkg::S_SIN_Q;
            rpv_pkg::S_RAD_DST:  n_state = rpv_pkg::S_RAD_DWT;
            rpv_pkg::S_RAD_DWT:  if (i_div_rsp.done) n_state = rpv_pkg::S_VTX_DST;
            rpv_pkg::S_VTX_DST:  n_state = rpv_pkg::S_VTX_DWT;
            rpv_pkg::S_VTX_DWT:  if (i_div_rsp.done) n_state = rpv_pkg::S_SIN_Q;
            rpv_pkg::S_SIN_Q:    n_state = rpv_pkg::S_SIN_X;
            rpv_pkg::S_SIN_X:    n_state = rpv_pkg::S_SIN_X2;
            rpv_pkg::S_SIN_X2:   n_state = rpv_pkg::S_SIN_T0;
            rpv_pkg::S_SIN_T0:   n_state = rpv_pkg::S_SIN_PT;
            rpv_pkg::S_SIN_PT:   n_state = rpv_pkg::S_SIN_RCP;
            rpv_pkg::S_SIN_RCP:  n_state = rpv_pkg::S_SIN_QT;
            rpv_pkg::S_SIN_QT:
                n_state = (r_k == 3'd4) ? rpv_pkg::S_SIN_S : rpv_pkg::S_SIN_PT;
            rpv_pkg::S_SIN_S:    n_state = rpv_pkg::S_SIN_END;
            rpv_pkg::S_SIN_END: begin
                case (r_sel)
                    rpv_pkg::SEL_RAD: n_state = rpv_pkg::S_RAD_DST;
                    rpv_pkg::SEL_COS: n_state = rpv_pkg::S_SIN_Q;
                    default:          n_state = rpv_pkg::S_SC_XA;
                endcase
            end
            rpv_pkg::S_SC_XA: n_state = rpv_pkg::S_SC_XB;
            rpv_pkg::S_SC_XB: n_state = rpv_pkg::S_SC_XC;
            rpv_pkg::S_SC_XC: n_state = rpv_pkg::S_SC_YA;
            rpv_pkg::S_SC_YA: n_state = rpv_pkg::S_SC_YB;
            rpv_pkg::S_SC_YB: n_state = rpv_pkg::S_SC_YC;
            rpv_pkg::S_SC_YC: n_state = rpv_pkg::S_EMIT;
            rpv_pkg::S_EMIT:
                if (out_free) n_state = is_last ? rpv_pkg::S_IDLE : rpv_pkg::S_VTX_DST;
            default: n_state = rpv_pkg::S_IDLE;
        endcase
    end

    // control outputs: queue pop, divider request, multiplier operands
    always_comb begin
        o_job_pop          = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = '0;
        o_div_req.divisor  = '0;
        mul_en             = 1'b0;
        mul_a              = '0;
        mul_b              = '0;
        k_off              = {r_i[5:0], r_job.circ};
        unique case (r_state)
            rpv_pkg::S_IDLE: o_job_pop = i_job_valid;
            rpv_pkg::S_HALF_DST, rpv_pkg::S_VTX_DST: begin
                if (r_state == rpv_pkg::S_HALF_DST) k_off = 7'd1;
                o_div_req.start    = 1'b1;
                o_div_req.dividend = {25'd0, k_off, 25'd0, r_job.n};
                o_div_req.divisor  = {23'd0, r_job.n, 1'b0};
            end
            rpv_pkg::S_RAD_DST: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = {3'd0, r_job.rad, r_cos_mag[30:1]};
                o_div_req.divisor  = r_cos_mag;
            end
            rpv_pkg::S_SIN_RCP: begin
                mul_en = 1'b1;
                mul_a  = {1'b0, rcp_dvd};
                mul_b  = rpv_pkg::sin_recip(r_k);
            end
            rpv_pkg::S_SIN_Q: begin
                mul_en = 1'b1;
                mul_a  = {1'b0, q_sin};
                mul_b  = {1'b0, rpv_pkg::PI_HALF_Q30};
            end
            rpv_pkg::S_SIN_X2: begin
                mul_en = 1'b1;
                mul_a  = {1'b0, r_x};
                mul_b  = {1'b0, r_x};
            end
            rpv_pkg::S_SIN_PT: begin
                mul_en = 1'b1;
                mul_a  = r_x2;
                mul_b  = {1'b0, r_t};
            end
            rpv_pkg::S_SIN_S: begin
                mul_en = 1'b1;
                mul_a  = {1'b0, r_x};
                mul_b  = {1'b0, r_t};
            end
            rpv_pkg::S_SC_XA, rpv_pkg::S_SC_YA: begin
                mul_en = 1'b1;
                mul_a  = {13'd0, r_rad[33:15]};
                mul_b  = {1'b0, sc_mag};
            end
            rpv_pkg::S_SC_XB, rpv_pkg::S_SC_YB: begin
                mul_en = 1'b1;
                mul_a  = {17'd0, r_rad[14:0]};
                mul_b  = {1'b0, sc_mag};
            end
            default: ;
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // offset = radius * trig, rounded half up in magnitude; center plus or minus offset is then saturated
    assign sc_y   = (r_state == rpv_pkg::S_SC_YA) || (r_state == rpv_pkg::S_SC_YB)
                 || (r_state == rpv_pkg::S_SC_YC);
    assign sc_mag = sc_y ? r_sin_mag : r_cos_mag;
    assign sc_neg = sc_y ? r_sin_neg : r_cos_neg;
    assign sc_ctr = sc_y ? r_job.cy : r_job.cx;
    assign sc_sum = {1'b0, r_a} + 52'd16384 + {21'd0, r_prod[45:15]};
    assign sc_off = {2'b00, sc_sum[51:15]};
    assign sc_res = sc_neg ? ({{7{sc_ctr[31]}}, sc_ctr} - sc_off)
                           : ({{7{sc_ctr[31]}}, sc_ctr} + sc_off);

    always_comb begin
        sc_clip = 1'b0;
        sc_sat  = sc_res[31:0];
        if (sc_res > 39'sd2147483647) begin
            sc_sat  = 32'h7FFF_FFFF;
            sc_clip = 1'b1;
        end else if (sc_res < -39'sd2147483648) begin
            sc_sat  = 32'h8000_0000;
            sc_clip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rpv_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == rpv_pkg::S_EMIT && out_free)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) r_prod <= mul_p;
        case (r_state)
            rpv_pkg::S_IDLE: begin
                if (i_job_valid) begin
                    r_job <= i_job;
                    r_rad <= {3'd0, i_job.rad};
                    r_i   <= '0;
                end
            end
            rpv_pkg::S_HALF_DWT: begin
                r_ph  <= i_div_rsp.quot[31:0] + rpv_pkg::QUARTER;
                r_sel <= rpv_pkg::SEL_RAD;
            end
            rpv_pkg::S_RAD_DWT: r_rad <= i_div_rsp.quot;
            rpv_pkg::S_VTX_DWT: begin
                r_vph <= vtx_ph;
                r_ph  <= vtx_ph + rpv_pkg::QUARTER;
                r_sel <= rpv_pkg::SEL_COS;
            end
            rpv_pkg::S_SIN_X: r_x <= r_prod[60:30];
            rpv_pkg::S_SIN_T0: begin
                r_x2 <= r_prod[61:30];
                r_t  <= rpv_pkg::ONE_Q30;
                r_k  <= '0;
            end
            rpv_pkg::S_SIN_QT: begin
                r_t <= rpv_pkg::ONE_Q30 - rcp_quo;
                r_k <= r_k + 3'd1;
            end
            rpv_pkg::S_SIN_END: begin
                case (r_sel)
                    rpv_pkg::SEL_RAD: r_cos_mag <= s_cap;
                    rpv_pkg::SEL_COS: begin
                        r_cos_mag <= s_cap;
                        r_cos_neg <= r_ph[31];
                        r_ph      <= r_vph;
                        r_sel     <= rpv_pkg::SEL_SIN;
                    end
                    default: begin
                        r_sin_mag <= s_cap;
                        r_sin_neg <= r_ph[31];
                    end
                endcase
            end
            rpv_pkg::S_SC_XB, rpv_pkg::S_SC_YB: r_a <= r_prod[50:0];
            rpv_pkg::S_SC_XC: begin
                r_vx     <= sc_sat;
                r_clip_x <= sc_clip;
            end
            rpv_pkg::S_SC_YC: begin
                r_vy    <= sc_sat;
                r_vclip <= r_clip_x || sc_clip;
            end
            rpv_pkg::S_EMIT: begin
                if (out_free) begin
                    r_out_x    <= r_vx;
                    r_out_y    <= r_vy;
                    r_out_clip <= r_vclip;
                    r_out_num  <= r_i[5:0];
                    r_out_last <= is_last;
                    r_i        <= r_i + 7'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_vertex_x      = r_out_x;
    assign o_vertex_y      = r_out_y;
    assign o_vertex_number = r_out_num;
    assign o_last_vertex   = r_out_last;
    assign o_clipped       = r_out_clip;

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_req.start |-> !i_div_rsp.busy)
        else $error("divider started while busy");

    a_vtx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rpv_pkg::S_EMIT |-> r_i < r_job.n)
        else $error("vertex index past side count");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == rpv_pkg::S_EMIT)
        else $error("result appeared outside emit");

endmodule
